// File: rtl/sarc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarc_pkg: shared definitions for the summed-area rectangle counter
// Field widths, defaults, request codes, command kinds and back-end states.
// ----------------------------------------------------------------------------
package sarc_pkg;

    localparam int COUNT_W      = 17;   // table entry and result count width
    localparam int GRID_W       = 9;    // grid_size register width
    localparam int COORD_W      = 8;    // query coordinate width
    localparam int MAX_SIDE_DEF = 256;  // default largest grid side
    localparam int FIFO_DEPTH   = 4;    // command queue depth

    localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_QUERY,
        CMD_ERROR
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_QRY1,
        BK_QRY2
    } t_back_state;

endpackage

// File: rtl/sarc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarc_if: request and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sarc_in_if;
    import sarc_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic               cell_marked;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_last;

    modport source (
        output valid, req_type, cell_marked, row_first, col_first, row_last, col_last,
        input  ready
    );
    modport sink (
        input  valid, req_type, cell_marked, row_first, col_first, row_last, col_last,
        output ready
    );
endinterface

interface sarc_out_if;
    import sarc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] marked_count;
    logic               query_error;

    modport source (
        output valid, marked_count, query_error,
        input  ready
    );
    modport sink (
        input  valid, marked_count, query_error,
        output ready
    );
endinterface

// File: rtl/sarc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarc_ram: generic RAM, one write port, two registered read ports
// ----------------------------------------------------------------------------
module sarc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// File: rtl/sarc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarc_fifo: short command queue between front and back
// ----------------------------------------------------------------------------
module sarc_fifo #(
    parameter type t_item = logic,
    parameter int  DEPTH  = sarc_pkg::FIFO_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);
    localparam int PW = $clog2(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [PW:0]   n_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(DEPTH)) else $error("queue count beyond depth");
endmodule

// File: rtl/sarc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarc_front: request intake and classification
// Holds grid_size and the load cursor; makes each beat a queue command, bar loads past the grid.
// ----------------------------------------------------------------------------
module sarc_front #(
    parameter int  MAX_SIDE = sarc_pkg::MAX_SIDE_DEF,
    parameter type t_cmd    = logic
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sarc_pkg::GRID_W-1:0] i_cfg_wdata,
    sarc_in_if.sink                     i_req,
    output logic                        o_push,
    output t_cmd                        o_cmd,
    input  logic                        i_full
);
    import sarc_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);

    logic [GRID_W-1:0] r_grid_size, n_grid_size;
    logic [CW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [SW-1:0]     r_row_sum, n_row_sum;
    logic              r_loaded, n_loaded;

    logic [SW-1:0] side;
    logic [SW-1:0] sum_new;
    logic          accept;
    logic          col_wrap;
    logic          row_wrap;
    logic          q_err;

    // effective side: zero acts as one, clamp to the table size
    always_comb begin
        if (r_grid_size == '0) begin
            side = SW'(1);
        end else if (32'(r_grid_size) > MAX_SIDE) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = SW'(r_grid_size);
        end
    end

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && i_req.ready;
    assign sum_new     = r_row_sum + SW'(i_req.cell_marked);
    assign col_wrap    = (32'(r_col) + 1) >= 32'(side);
    assign row_wrap    = (32'(r_row) + 1) >= 32'(side);
    assign q_err       = !r_loaded
                      || (32'(i_req.row_last) >= 32'(side))
                      || (32'(i_req.col_last) >= 32'(side))
                      || (i_req.row_first > i_req.row_last)
                      || (i_req.col_first > i_req.col_last);

    always_comb begin
        n_grid_size = r_grid_size;
        n_row       = r_row;
        n_col       = r_col;
        n_row_sum   = r_row_sum;
        n_loaded    = r_loaded;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (accept) begin
            if (i_req.req_type == REQ_LOAD) begin
                if (!r_loaded) begin
                    o_push         = 1'b1;
                    o_cmd.kind     = CMD_LOAD;
                    o_cmd.row_a    = r_row;
                    o_cmd.col_a    = r_col;
                    o_cmd.row_b    = r_row - CW'(1);
                    o_cmd.has_top  = (r_row != '0);
                    o_cmd.has_left = 1'b0;
                    o_cmd.sum      = sum_new;
                    if (col_wrap) begin
                        n_col     = '0;
                        n_row_sum = '0;
                        if (row_wrap) begin
                            n_row    = '0;
                            n_loaded = 1'b1;
                        end else begin
                            n_row = r_row + CW'(1);
                        end
                    end else begin
                        n_col     = r_col + CW'(1);
                        n_row_sum = sum_new;
                    end
                end
            end else begin
                o_push         = 1'b1;
                o_cmd.kind     = q_err ? CMD_ERROR : CMD_QUERY;
                o_cmd.row_a    = CW'(i_req.row_last);
                o_cmd.col_a    = CW'(i_req.col_last);
                o_cmd.row_b    = CW'(i_req.row_first - COORD_W'(1));
                o_cmd.col_b    = CW'(i_req.col_first - COORD_W'(1));
                o_cmd.has_top  = (i_req.row_first != '0);
                o_cmd.has_left = (i_req.col_first != '0);
            end
        end
        if (i_cfg_we) begin
            n_grid_size = i_cfg_wdata;
            n_row       = '0;
            n_col       = '0;
            n_row_sum   = '0;
            n_loaded    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_row_sum   <= '0;
            r_loaded    <= 1'b0;
        end else begin
            r_grid_size <= n_grid_size;
            r_row       <= n_row;
            r_col       <= n_col;
            r_row_sum   <= n_row_sum;
            r_loaded    <= n_loaded;
        end
    end

    a_cursor_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded |-> (r_row == '0 && r_col == '0 && r_row_sum == '0))
        else $error("load cursor moved after grid complete");
    a_drop_late_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_LOAD && r_loaded) |-> !o_push)
        else $error("load beyond grid reached the queue");
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("command pushed into full queue");
endmodule

// File: rtl/sarc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarc_back: table update and rectangle evaluation
// Runs one command at a time against the dual-read-port table.
// ----------------------------------------------------------------------------
module sarc_back #(
    parameter int  MAX_SIDE = sarc_pkg::MAX_SIDE_DEF,
    parameter type t_cmd    = logic
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    sarc_out_if.source  o_res
);
    import sarc_pkg::*;

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [COUNT_W-1:0] r_part, n_part;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic               r_out_err, n_out_err;

    logic               out_free;
    logic               res_push;
    logic [COUNT_W-1:0] res_count;
    logic               res_err;
    logic               ram_we;
    logic [AW-1:0]      waddr;
    logic [COUNT_W-1:0] wdata;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic [COUNT_W-1:0] rdata_a;
    logic [COUNT_W-1:0] rdata_b;

    sarc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign out_free = !r_out_valid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.kind)
                        CMD_LOAD:  n_state = BK_LOAD;
                        CMD_QUERY: n_state = BK_QRY1;
                        default:   n_state = BK_IDLE;
                    endcase
                end
            end
            BK_LOAD: n_state = BK_IDLE;
            BK_QRY1: n_state = BK_QRY2;
            BK_QRY2: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs: reads are issued from the queue head on pop, then from r_cmd
    always_comb begin
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        waddr     = {r_cmd.row_a, r_cmd.col_a};
        wdata     = (r_cmd.has_top ? rdata_a : '0) + COUNT_W'(r_cmd.sum);
        raddr_a   = {r_cmd.row_b, r_cmd.col_b};
        raddr_b   = {r_cmd.row_b, r_cmd.col_a};
        n_part    = r_part;
        res_push  = 1'b0;
        res_count = '0;
        res_err   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop = !i_empty && (i_cmd.kind == CMD_LOAD || out_free);
                if (i_cmd.kind == CMD_LOAD) begin
                    raddr_a = {i_cmd.row_b, i_cmd.col_a};
                end else begin
                    raddr_a = {i_cmd.row_a, i_cmd.col_a};
                end
                raddr_b = {i_cmd.row_a, i_cmd.col_b};
                if (o_pop && i_cmd.kind == CMD_ERROR) begin
                    res_push = 1'b1;
                    res_err  = 1'b1;
                end
            end
            BK_LOAD: begin
                ram_we = 1'b1;
            end
            BK_QRY1: begin
                // bottom-right less bottom-left
                n_part = rdata_a - (r_cmd.has_left ? rdata_b : '0);
            end
            BK_QRY2: begin
                // plus top-left, less top-right
                res_push  = 1'b1;
                res_count = r_part
                          + ((r_cmd.has_top && r_cmd.has_left) ? rdata_a : '0)
                          - (r_cmd.has_top ? rdata_b : '0);
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;
        if (res_push) begin
            n_out_valid = 1'b1;
            n_out_count = res_count;
            n_out_err   = res_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        r_part      <= n_part;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.marked_count = r_out_count;
    assign o_res.query_error  = r_out_err;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> out_free) else $error("result register overwritten");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_count == '0))
        else $error("rejected query carries a count");
    a_query_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_QRY1) |=> (r_state == BK_QRY2))
        else $error("query lost its second read pair");
endmodule

// File: rtl/summed_area_rectangle_count.sv
`timescale 1ns / 1ps
// Results: a valid query's count is registered after two table read pairs;
//   a rejected query's error flag is registered as it leaves the queue; loads give no result.
// Table use: a load reads the entry above, then writes its cell;
//   a valid query reads four corners as two dual-port read pairs.
// Reset: grid_size returns to 256 and loading restarts; the table is not cleared.
// ----------------------------------------------------------------------------
// summed_area_rectangle_count: rectangle counts over a one-bit grid
// Builds a summed-area table as cells stream in, then answers inclusive
// rectangle queries by inclusion-exclusion over up to four table entries.
// ----------------------------------------------------------------------------
module summed_area_rectangle_count #(
    parameter int MAX_SIDE = sarc_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sarc_pkg::GRID_W-1:0] i_cfg_wdata,
    sarc_in_if.sink                     i_req,
    sarc_out_if.source                  o_res
);
    import sarc_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);

    // One queue command. For a load: row_a/col_a is the cell being written,
    // row_b the row above, sum the running row total including this cell.
    // For a query: a = last row/column, b = first row/column less one, and
    // the has_ flags say whether the top and left strips exist at all.
    typedef struct packed {
        t_cmd_kind     kind;
        logic [CW-1:0] row_a;
        logic [CW-1:0] col_a;
        logic [CW-1:0] row_b;
        logic [CW-1:0] col_b;
        logic          has_top;
        logic          has_left;
        logic [SW-1:0] sum;
    } t_cmd;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Front: owns grid_size and the load cursor, so every beat is classified
    // in arrival order. Loads after the grid is complete are dropped here.
    sarc_front #(
        .MAX_SIDE (MAX_SIDE),
        .t_cmd    (t_cmd)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    // Short queue decouples intake from table work; the front keeps taking
    // beats while the back waits on a stalled result, until the queue is full.
    sarc_fifo #(
        .t_item (t_cmd),
        .DEPTH  (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (head_cmd),
        .o_empty (empty)
    );

    // Back: table RAM plus the sequencer; commands run strictly in order, so a
    // load's read of the row above always sees the earlier write.
    sarc_back #(
        .MAX_SIDE (MAX_SIDE),
        .t_cmd    (t_cmd)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule
